// ----- src/tlbf_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbf_pkg
// Beat types, result codes and reset-content helpers for the TLB lookup block.
// ----------------------------------------------------------------------------
package tlbf_pkg;

	localparam int PAGE_W   = 8;
	localparam int OFFSET_W = 12;
	localparam int FRAME_W  = 8;
	localparam int CODE_W   = 2;

	// lookup_source codes
	localparam logic [CODE_W-1:0] SRC_TLB  = 2'd0;
	localparam logic [CODE_W-1:0] SRC_PT   = 2'd1;
	localparam logic [CODE_W-1:0] SRC_NONE = 2'd2;

	// tlb_action codes
	localparam logic [CODE_W-1:0] ACT_NONE    = 2'd0;
	localparam logic [CODE_W-1:0] ACT_FILL    = 2'd1;
	localparam logic [CODE_W-1:0] ACT_REPLACE = 2'd2;

	// slots holding a mapping at reset
	localparam int RST_SLOTS = 3;

	typedef struct packed {
		logic [PAGE_W-1:0]   page_number;
		logic [OFFSET_W-1:0] page_offset;
	} in_beat_t;

	typedef struct packed {
		logic [CODE_W-1:0]   lookup_source;
		logic [FRAME_W-1:0]  frame_number;
		logic [OFFSET_W-1:0] frame_offset;
		logic [CODE_W-1:0]   tlb_action;
	} out_beat_t;

	// reset contents of a slot: slot i < 3 holds page i+1
	function automatic logic [PAGE_W-1:0] rst_page(input logic [7:0] slot);
		rst_page = (slot < 8'(RST_SLOTS)) ? slot + 8'd1 : '0;
	endfunction

	// ... and frame i+2
	function automatic logic [FRAME_W-1:0] rst_frame(input logic [7:0] slot);
		rst_frame = (slot < 8'(RST_SLOTS)) ? slot + 8'd2 : '0;
	endfunction

	// fixed page table: page k maps to frame k+1
	function automatic logic [FRAME_W-1:0] pt_frame(input logic [PAGE_W-1:0] page);
		pt_frame = page + 8'd1;
	endfunction

endpackage

// ----- src/tlb_lookup_fifo_refill.sv -----
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_refill
// Fully associative TLB lookup with page-table refill and round-robin
// replacement, searched one slot per cycle by a shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one logical address
//   per beat: page number and page offset. Output channel
//   (out_valid/out_ready/out_data) returns one beat per input: lookup
//   source, frame, offset copied through, and the TLB action taken.
//   One lookup is in flight at a time; in_ready is high only while idle.
//   Sequence: a TLB hit in slot k ends the walk at slot k; a miss walks all
//   TLB_ENTRIES slots, then passes through the fill state. The slot walk
//   goes through the registered tag/frame RAM read port, one slot per cycle.
//   The next input beat is taken in the cycle after the result is loaded
//   into the output register.
//   A waiting output beat does not block the next lookup; only a second
//   finished result waits (in its final state) until the output register
//   frees up.
//   Reset: slots 0..2 hold pages 1..3 mapped to frames 2..4 and are valid,
//   the rest are empty, the replacement pointer is zero. Slots never written
//   since reset read their reset mapping through a per-slot written flag,
//   so no clearing pass is needed.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_refill #(
	parameter int TLB_ENTRIES = 8,
	parameter int PT_ENTRIES  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tlbf_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tlbf_pkg::out_beat_t out_data
);

	import tlbf_pkg::*;

	localparam int IDX_W = $clog2(TLB_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TLB_ENTRIES - 1);
	localparam logic [PAGE_W-1:0] PT_MAX = PAGE_W'(PT_ENTRIES);
	localparam int ENT_W = PAGE_W + FRAME_W;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]             state_q;
	logic [PAGE_W-1:0]      page_q;
	logic [OFFSET_W-1:0]    offset_q;
	logic [IDX_W-1:0]       idx_q;       // slot address issued to RAM
	logic [IDX_W-1:0]       chk_idx_q;   // slot whose data is on rdata
	logic                   chk_q;       // rdata valid for chk_idx_q
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [IDX_W-1:0]       ptr_q;
	logic [TLB_ENTRIES-1:0] valid_q;
	logic [TLB_ENTRIES-1:0] wr_q;        // slot written since reset
	out_beat_t              res_q;
	out_beat_t              out_q;
	logic                   out_valid_q;

	// RAM: {page, frame} per slot
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [ENT_W-1:0]  ram_wdata;
	logic [ENT_W-1:0]  ram_rdata;

	tlbf_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TLB_ENTRIES)
	) u_ent_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// slot data under check: RAM content once written, reset mapping before
	logic [PAGE_W-1:0]  chk_page;
	logic [FRAME_W-1:0] chk_frame;
	logic               chk_valid;
	logic               chk_hit;

	always_comb begin
		if (wr_q[chk_idx_q]) begin
			chk_page  = ram_rdata[ENT_W-1:FRAME_W];
			chk_frame = ram_rdata[FRAME_W-1:0];
		end else begin
			chk_page  = rst_page(8'(chk_idx_q));
			chk_frame = rst_frame(8'(chk_idx_q));
		end
		chk_valid = valid_q[chk_idx_q];
		chk_hit   = chk_q && chk_valid && (chk_page == page_q);
	end

	// refill decision
	logic             pt_hit;
	logic [IDX_W-1:0] fill_slot;

	assign pt_hit    = (page_q != '0) && (page_q <= PT_MAX);
	assign fill_slot = free_found_q ? free_idx_q : ptr_q;

	assign ram_we    = (state_q == ST_FILL) && pt_hit;
	assign ram_waddr = fill_slot;
	assign ram_wdata = {page_q, pt_frame(page_q)};

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			chk_idx_q    <= '0;
			chk_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			ptr_q        <= '0;
			wr_q         <= '0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				valid_q[i] <= (i < RST_SLOTS);
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q        <= '0;
						chk_q        <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_q     <= 1'b1;
					chk_idx_q <= idx_q;
					if (idx_q != LAST_SLOT) begin
						idx_q <= idx_q + 1'b1;
					end
					if (chk_q) begin
						// lowest empty slot seen so far
						if (!chk_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= chk_idx_q;
						end
						if (chk_hit) begin
							state_q <= ST_DONE;
						end else if (chk_idx_q == LAST_SLOT) begin
							state_q <= ST_FILL;
						end
					end
				end
				ST_FILL: begin
					if (pt_hit) begin
						valid_q[fill_slot] <= 1'b1;
						wr_q[fill_slot]    <= 1'b1;
						if (!free_found_q) begin
							ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			page_q   <= in_data.page_number;
			offset_q <= in_data.page_offset;
		end
		if (state_q == ST_SCAN && chk_hit) begin
			res_q.lookup_source <= SRC_TLB;
			res_q.frame_number  <= chk_frame;
			res_q.frame_offset  <= offset_q;
			res_q.tlb_action    <= ACT_NONE;
		end
		if (state_q == ST_FILL) begin
			res_q.frame_offset <= offset_q;
			if (pt_hit) begin
				res_q.lookup_source <= SRC_PT;
				res_q.frame_number  <= pt_frame(page_q);
				res_q.tlb_action    <= free_found_q ? ACT_FILL : ACT_REPLACE;
			end else begin
				res_q.lookup_source <= SRC_NONE;
				res_q.frame_number  <= '0;
				res_q.tlb_action    <= ACT_NONE;
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/tlbf_ram.sv -----
// ----------------------------------------------------------------------------
// tlbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/tlbf_chk.sv -----
// ----------------------------------------------------------------------------
// tlbf_chk
// Port-level checks for the TLB lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module tlbf_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tlbf_pkg::out_beat_t out_data
);

	import tlbf_pkg::*;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// one lookup at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a lookup is in flight");

	// miss everywhere: no frame, no TLB change
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.lookup_source == SRC_NONE |->
			out_data.frame_number == '0 && out_data.tlb_action == ACT_NONE)
		else $error("not-found result carries a frame or action");

	// TLB hit leaves the TLB alone
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.lookup_source == SRC_TLB |->
			out_data.tlb_action == ACT_NONE)
		else $error("TLB hit reported a TLB action");

	// page-table hit always refills
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.lookup_source == SRC_PT |->
			(out_data.tlb_action == ACT_FILL || out_data.tlb_action == ACT_REPLACE))
		else $error("page-table hit without refill");

endmodule

bind tlb_lookup_fifo_refill tlbf_chk u_tlbf_chk (.*);
